// ===== src/small_matrix_inverse_top_defines.svh =====
// Assertion macros shared by the checker of the matrix inverse block.
// Depends on nothing; included by the checker file only.
`ifndef SMALL_MATRIX_INVERSE_TOP_DEFINES_SVH
`define SMALL_MATRIX_INVERSE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/smi_pkg.sv =====
// Package of the matrix inverse block: widths, datapath commands, controller states.
// Depends on nothing.
`default_nettype none
package smi_pkg;

    localparam int EL_W       = 16;
    localparam int COF_W      = 33;
    localparam int PROD_W     = 49;
    localparam int DET_W      = 52;
    localparam int QUO_W      = 57;
    localparam int REM_W      = 53;
    localparam int DIV_CNT_W  = 6;
    localparam int IDX_W      = 4;
    localparam int OUT_W      = 32;
    localparam int SIZE_W     = 2;
    localparam int FRAC_SHIFT = 24;
    localparam int STORE_D    = 9;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP, DP_STORE, DP_LDX, DP_MULA, DP_MULC, DP_ACC_CLR, DP_ACC_SET, DP_ACC_SUB,
        DP_ACC_ADD, DP_ACC_X, DP_COF_WR, DP_COF_ONE, DP_DET_WR, DP_DIV_INIT, DP_DIV_STEP,
        DP_OUT
    } t_dp_op;

    typedef enum logic [2:0] {
        S_LOAD, S_COF, S_DET, S_IDX, S_DIV, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] cidx;
        logic             neg;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
    } t_dp_status;

    // Row-major position of (row, col) with the given stride.
    function automatic logic [IDX_W-1:0] f_addr(logic [1:0] row, logic [1:0] col,
                                                logic [1:0] stride);
        f_addr = IDX_W'(IDX_W'(row) * IDX_W'(stride) + IDX_W'(col));
    endfunction

    // Lower and upper index left when one of three is removed.
    function automatic logic [1:0] f_lo(logic [1:0] i);
        f_lo = (i == 2'd0) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] f_hi(logic [1:0] i);
        f_hi = (i == 2'd2) ? 2'd1 : 2'd2;
    endfunction

    function automatic logic [IDX_W-1:0] f_total(logic [1:0] n);
        case (n)
            2'd1:    f_total = 4'd1;
            2'd2:    f_total = 4'd4;
            default: f_total = 4'd9;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== src/smi_if.sv =====
// Channel interfaces of the matrix inverse block: configuration, element input, result output.
// Depends on nothing.
`default_nettype none
interface smi_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] matrix_size;
    modport source (output valid, output matrix_size, input ready);
    modport sink (input valid, input matrix_size, output ready);
endinterface

interface smi_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] element;
    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

interface smi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] inverse_entry;
    logic [3:0]         entry_index;
    logic               singular;
    logic               saturated;
    logic               last;
    modport source (output valid, output inverse_entry, output entry_index, output singular,
                    output saturated, output last, input ready);
    modport sink (input valid, input inverse_entry, input entry_index, input singular,
                  input saturated, input last, output ready);
endinterface
`default_nettype wire

// ===== src/smi_ctrl.sv =====
// Controller of the matrix inverse block: load counting, cofactor, determinant and divide sequencing.
// Depends on smi_pkg.
`default_nettype none
module smi_ctrl #(
    parameter int MAX_SIZE = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [1:0]                i_cfg_size,
    output logic                      o_cfg_ready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output smi_pkg::t_dp_cmd          o_cmd,
    input  smi_pkg::t_dp_status       i_status
);
    import smi_pkg::*;

    localparam logic [1:0] MAX_N = 2'(MAX_SIZE);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    t_state                r_state, n_state;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [IDX_W-1:0]      r_cnt, n_cnt;
    logic [1:0]            r_n, n_n;
    logic [1:0]            r_i, n_i;
    logic [1:0]            r_j, n_j;
    logic [2:0]            r_step, n_step;
    logic [DIV_CNT_W-1:0]  r_div, n_div;

    logic [1:0]            w_cur_n;
    logic [IDX_W-1:0]      w_cnt_inc;
    logic                  w_row_end;
    logic                  w_mat_end;

    // Clamp the configured size to the supported range.
    always_comb begin
        w_cur_n = r_size;
        if (w_cur_n == 2'd0) begin
            w_cur_n = 2'd1;
        end
        if (w_cur_n > MAX_N) begin
            w_cur_n = MAX_N;
        end
    end

    assign w_cnt_inc = IDX_W'(r_cnt + 4'd1);
    assign w_row_end = (r_j == 2'(r_n - 2'd1));
    assign w_mat_end = w_row_end && (r_i == 2'(r_n - 2'd1));
    assign o_cfg_ready = 1'b1;

    // State and loop registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_size  <= SIZE_RESET;
            r_cnt   <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_step  <= '0;
            r_div   <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_step  <= n_step;
            r_div   <= n_div;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_step      = r_step;
        n_div       = r_div;
        o_cmd       = '0;
        o_cmd.op    = DP_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        if (i_cfg_valid) begin
            n_size = i_cfg_size;
        end

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op   = DP_STORE;
                    o_cmd.addr = r_cnt;
                    if (w_cnt_inc >= f_total(w_cur_n)) begin
                        n_cnt   = '0;
                        n_n     = w_cur_n;
                        n_i     = '0;
                        n_j     = '0;
                        n_step  = '0;
                        n_state = S_COF;
                    end else begin
                        n_cnt = w_cnt_inc;
                    end
                end
            end

            S_COF: begin
                o_cmd.cidx = f_addr(r_i, r_j, 2'd3);
                o_cmd.neg  = r_i[0] ^ r_j[0];
                n_step     = 3'(r_step + 3'd1);
                case (r_n)
                    2'd1: begin
                        o_cmd.op = DP_COF_ONE;
                    end
                    2'd2: begin
                        case (r_step)
                            3'd0: begin
                                o_cmd.op   = DP_LDX;
                                o_cmd.addr = f_addr({1'b0, ~r_i[0]}, {1'b0, ~r_j[0]}, r_n);
                            end
                            3'd1:    o_cmd.op = DP_ACC_X;
                            default: o_cmd.op = DP_COF_WR;
                        endcase
                    end
                    default: begin
                        case (r_step)
                            3'd0: begin
                                o_cmd.op   = DP_LDX;
                                o_cmd.addr = f_addr(f_lo(r_i), f_lo(r_j), r_n);
                            end
                            3'd1: begin
                                o_cmd.op   = DP_MULA;
                                o_cmd.addr = f_addr(f_hi(r_i), f_hi(r_j), r_n);
                            end
                            3'd2:    o_cmd.op = DP_ACC_SET;
                            3'd3: begin
                                o_cmd.op   = DP_LDX;
                                o_cmd.addr = f_addr(f_hi(r_i), f_lo(r_j), r_n);
                            end
                            3'd4: begin
                                o_cmd.op   = DP_MULA;
                                o_cmd.addr = f_addr(f_lo(r_i), f_hi(r_j), r_n);
                            end
                            3'd5:    o_cmd.op = DP_ACC_SUB;
                            default: o_cmd.op = DP_COF_WR;
                        endcase
                    end
                endcase
                // Advance to the next cofactor after its write.
                if (o_cmd.op == DP_COF_WR || o_cmd.op == DP_COF_ONE) begin
                    n_step = '0;
                    if (w_mat_end) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_DET;
                    end else if (w_row_end) begin
                        n_i = 2'(r_i + 2'd1);
                        n_j = '0;
                    end else begin
                        n_j = 2'(r_j + 2'd1);
                    end
                end
            end

            // Expansion along the first row.
            S_DET: begin
                o_cmd.addr = f_addr(2'd0, r_j, r_n);
                o_cmd.cidx = f_addr(2'd0, r_j, 2'd3);
                case (r_step)
                    3'd0: begin
                        o_cmd.op = DP_ACC_CLR;
                        n_step   = 3'd1;
                    end
                    3'd1: begin
                        o_cmd.op = DP_MULC;
                        n_step   = 3'd2;
                    end
                    3'd2: begin
                        o_cmd.op = DP_ACC_ADD;
                        if (w_row_end) begin
                            n_step = 3'd3;
                        end else begin
                            n_j    = 2'(r_j + 2'd1);
                            n_step = 3'd1;
                        end
                    end
                    default: begin
                        o_cmd.op = DP_DET_WR;
                        n_i      = '0;
                        n_j      = '0;
                        n_step   = '0;
                        n_state  = S_IDX;
                    end
                endcase
            end

            // Adjugate entry (i, j) is the cofactor at (j, i).
            S_IDX: begin
                if (i_status.det_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op   = DP_DIV_INIT;
                    o_cmd.cidx = f_addr(r_j, r_i, 2'd3);
                    n_div      = '0;
                    n_state    = S_DIV;
                end
            end

            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_div    = DIV_CNT_W'(r_div + 1'b1);
                if (r_div == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                o_cmd.op   = DP_OUT;
                o_cmd.idx  = f_addr(r_i, r_j, r_n);
                o_cmd.last = w_mat_end;
                n_state    = S_OUT;
            end

            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDX;
                    if (w_mat_end) begin
                        n_state = S_LOAD;
                    end else if (w_row_end) begin
                        n_i = 2'(r_i + 2'd1);
                        n_j = '0;
                    end else begin
                        n_j = 2'(r_j + 2'd1);
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/smi_datapath.sv =====
// Datapath of the matrix inverse block: element store, cofactor array, multiplier,
// accumulator, bit-serial divider and output register. Depends on smi_pkg.
`default_nettype none
module smi_datapath #(
    parameter int ELEMENT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic signed [15:0]        i_element,
    input  smi_pkg::t_dp_cmd          i_cmd,
    output smi_pkg::t_dp_status       o_status,
    output logic signed [31:0]        o_entry,
    output logic [3:0]                o_index,
    output logic                      o_singular,
    output logic                      o_saturated,
    output logic                      o_last
);
    import smi_pkg::*;

    localparam int SH = EL_W - ELEMENT_BITS;

    logic signed [EL_W-1:0]   r_mem [STORE_D];
    logic signed [COF_W-1:0]  r_cof [STORE_D];
    logic signed [EL_W-1:0]   r_x;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DET_W-1:0]  r_acc;
    logic signed [DET_W-1:0]  r_det;
    logic [QUO_W-1:0]         r_quo;
    logic [REM_W-1:0]         r_rem;
    logic [DET_W-1:0]         r_den;
    logic                     r_neg;

    logic signed [EL_W-1:0]   w_shl, w_ext, w_rd;
    logic signed [EL_W-1:0]   w_ma;
    logic signed [COF_W-1:0]  w_mb, w_cof_rd, w_cof_acc;
    logic signed [PROD_W-1:0] w_prod;
    logic [COF_W-1:0]         w_cof_mag;
    logic [REM_W-1:0]         w_trial;
    logic                     w_fit;
    logic                     w_sat_pos, w_sat_neg;

    // Keep the low element bits, sign-extended.
    assign w_shl = i_element <<< SH;
    assign w_ext = w_shl >>> SH;

    assign w_rd     = r_mem[i_cmd.addr];
    assign w_cof_rd = r_cof[i_cmd.cidx];
    assign o_status.det_zero = (r_det == '0);

    // Shared multiplier operands: element pair or element times cofactor.
    always_comb begin
        if (i_cmd.op == DP_MULA) begin
            w_ma = r_x;
            w_mb = COF_W'(w_rd);
        end else begin
            w_ma = w_rd;
            w_mb = w_cof_rd;
        end
    end
    assign w_prod = w_ma * w_mb;

    assign w_cof_acc = r_acc[COF_W-1:0];
    assign w_cof_mag = w_cof_rd[COF_W-1] ? COF_W'(-w_cof_rd) : COF_W'(w_cof_rd);

    // One restoring division step.
    assign w_trial = {r_rem[REM_W-2:0], r_quo[QUO_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // Range checks on the quotient magnitude.
    assign w_sat_pos = |r_quo[QUO_W-1:OUT_W-1];
    assign w_sat_neg = (|r_quo[QUO_W-1:OUT_W]) || (r_quo[OUT_W-1] && |r_quo[OUT_W-2:0]);

    // Element store and cofactor array.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_STORE) begin
            r_mem[i_cmd.addr] <= w_ext;
        end
        if (i_cmd.op == DP_COF_WR) begin
            r_cof[i_cmd.cidx] <= i_cmd.neg ? COF_W'(-w_cof_acc) : w_cof_acc;
        end else if (i_cmd.op == DP_COF_ONE) begin
            r_cof[i_cmd.cidx] <= COF_W'(1);
        end
    end

    // Multiplier, accumulator and determinant.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LDX:     r_x    <= w_rd;
            DP_MULA,
            DP_MULC:    r_prod <= w_prod;
            DP_ACC_CLR: r_acc  <= '0;
            DP_ACC_SET: r_acc  <= DET_W'(r_prod);
            DP_ACC_SUB: r_acc  <= DET_W'(r_acc - DET_W'(r_prod));
            DP_ACC_ADD: r_acc  <= DET_W'(r_acc + DET_W'(r_prod));
            DP_ACC_X:   r_acc  <= DET_W'(r_x);
            DP_DET_WR:  r_det  <= r_acc;
            default: begin
            end
        endcase
    end

    // Divider on magnitudes; the sign is applied at the output.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_DIV_INIT) begin
            r_quo <= {w_cof_mag, {FRAC_SHIFT{1'b0}}};
            r_rem <= '0;
            r_den <= r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
            r_neg <= w_cof_rd[COF_W-1] ^ r_det[DET_W-1];
        end else if (i_cmd.op == DP_DIV_STEP) begin
            r_rem <= w_fit ? REM_W'(w_trial - {1'b0, r_den}) : w_trial;
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
        end
    end

    // Output register with saturation and the singular case.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_OUT) begin
            o_index    <= i_cmd.idx;
            o_last     <= i_cmd.last;
            o_singular <= o_status.det_zero;
            if (o_status.det_zero) begin
                o_entry     <= '0;
                o_saturated <= 1'b0;
            end else if (r_neg) begin
                o_saturated <= w_sat_neg;
                o_entry     <= w_sat_neg ? 32'sh8000_0000 : OUT_W'(-r_quo[OUT_W-1:0]);
            end else begin
                o_saturated <= w_sat_pos;
                o_entry     <= w_sat_pos ? 32'sh7FFF_FFFF : OUT_W'(r_quo[OUT_W-1:0]);
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/small_matrix_inverse_top.sv =====
// Matrix inverse of size 1 to 3: elements load one per cycle; after the last one the block
// computes the cofactors, then the determinant, and then each entry in turn through the
// one-bit-per-cycle divider, which is skipped for a singular matrix. No elements are accepted
// while a matrix is being processed. Reset clears the controller and sets the size register
// to 3; the stores are not cleared. Depends on smi_pkg, smi_if, smi_ctrl and smi_datapath.
`default_nettype none
module small_matrix_inverse_top #(
    parameter int MAX_SIZE     = 3,
    parameter int ELEMENT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smi_cfg_if.sink   i_cfg,
    smi_in_if.sink    i_in,
    smi_out_if.source o_out
);
    import smi_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    smi_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_size  (i_cfg.matrix_size),
        .o_cfg_ready (i_cfg.ready),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Arithmetic and storage.
    smi_datapath #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_element   (i_in.element),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_entry     (o_out.inverse_entry),
        .o_index     (o_out.entry_index),
        .o_singular  (o_out.singular),
        .o_saturated (o_out.saturated),
        .o_last      (o_out.last)
    );

endmodule
`default_nettype wire

// ===== src/smi_checker.sv =====
// Port-level checker of the matrix inverse block and its bind to the top level.
// Depends on small_matrix_inverse_top_defines.svh.
`default_nettype none
`include "small_matrix_inverse_top_defines.svh"
module smi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_entry,
    input logic        i_singular,
    input logic        i_saturated,
    input logic        i_last
);
    // A stalled result holds.
    `SMI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_entry))
    // Singular entries are zero and never clamped.
    `SMI_ASSERT_NOW(a_singular_zero, i_clk, i_rst_n, i_out_valid && i_singular, (i_entry == 32'd0) && !i_saturated)
    // A clamped entry sits at one of the range limits.
    `SMI_ASSERT_NOW(a_sat_limit, i_clk, i_rst_n, i_out_valid && i_saturated, (i_entry == 32'h7FFF_FFFF) || (i_entry == 32'h8000_0000))
    // No element is taken while results are pending.
    `SMI_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_in_ready, !i_out_valid)
    // After the last entry transfers, the block returns to loading.
    `SMI_ASSERT_NEXT(a_last_reload, i_clk, i_rst_n, i_out_valid && i_out_ready && i_last, i_in_ready)
endmodule

bind small_matrix_inverse_top smi_checker u_smi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_entry     (o_out.inverse_entry),
    .i_singular  (o_out.singular),
    .i_saturated (o_out.saturated),
    .i_last      (o_out.last)
);
`default_nettype wire
